// ===== rtl/core/sts_pkg.sv =====
`timescale 1ns / 1ps

package sts_pkg;

   localparam int STS_MAX_STATEMENT = 4096;
   localparam int STS_KEYWORD_CHARS = 7;
   localparam int STS_KEYWORDS      = 10;
   localparam int STS_MAX_RECS      = 3;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUM,
      MODE_STR
   } scan_mode_type;

   localparam logic [4:0] KIND_ERROR  = 5'd0;
   localparam logic [4:0] KIND_IDENT  = 5'd10;
   localparam logic [4:0] KIND_NUMBER = 5'd11;
   localparam logic [4:0] KIND_STRING = 5'd12;
   localparam logic [4:0] KIND_COMMA  = 5'd13;
   localparam logic [4:0] KIND_SEMI   = 5'd14;
   localparam logic [4:0] KIND_LPAREN = 5'd15;
   localparam logic [4:0] KIND_RPAREN = 5'd16;
   localparam logic [4:0] KIND_STAR   = 5'd17;
   localparam logic [4:0] KIND_EQUAL  = 5'd18;
   localparam logic [4:0] KIND_END    = 5'd19;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_INVALID = 2'd1;
   localparam logic [1:0] STAT_UNTERM  = 2'd2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [11:0] token_start;
      logic [12:0] token_length;
      logic [1:0]  status;
      logic        last_of_run;
   } rsp_type;

   // keyword text, first character in the low byte
   localparam logic [63:0] KW_TEXT [STS_KEYWORDS] = '{
      64'h0000_5443_454C_4553,   // SELECT
      64'h0000_5452_4553_4E49,   // INSERT
      64'h0000_4554_4145_5243,   // CREATE
      64'h0000_0045_4C42_4154,   // TABLE
      64'h0000_0000_4F54_4E49,   // INTO
      64'h0000_0000_4D4F_5246,   // FROM
      64'h0000_0045_5245_4857,   // WHERE
      64'h0000_5345_554C_4156,   // VALUES
      64'h0000_0000_0054_4E49,   // INT
      64'h0052_4148_4352_4156    // VARCHAR
   };

   localparam logic [3:0] KW_LEN [STS_KEYWORDS] = '{
      4'd6, 4'd6, 4'd6, 4'd5, 4'd4, 4'd4, 4'd5, 4'd6, 4'd3, 4'd7
   };

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_word(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic logic [7:0] to_upper(logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic logic [4:0] sym_kind(logic [7:0] c);
      logic [4:0] k;
      case (c)
         ",":     k = KIND_COMMA;
         ";":     k = KIND_SEMI;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "*":     k = KIND_STAR;
         "=":     k = KIND_EQUAL;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] kw_kind(logic [63:0] w, logic [3:0] n, logic over);
      logic [4:0] k;
      k = KIND_IDENT;
      if (!over) begin
         for (int i = 0; i < STS_KEYWORDS; i++) begin
            if (KW_LEN[i] == n && KW_TEXT[i] == w) begin
               k = 5'(i);
            end
         end
      end
      return k;
   endfunction

endpackage

// ===== rtl/core/sql_token_scanner_unit.sv =====
`timescale 1ns / 1ps
// channel   ports                           word
// -------   -----------------------------   ----------------------------------
// input     req_valid req_ready req_word    char_code, last_char
// result    rsp_valid rsp_ready rsp_word    token_kind, token_start,
//                                           token_length, status, last_of_run
//
// One byte per cycle when each byte yields at most one record and rsp_ready
// is held high; a byte that yields k records (k up to 3) holds the result
// port until all k are taken. Path: input register, then the record buffer.
// Synchronous active-high reset empties both registers and clears scan state.
// A stalled result side stops the input only once the input register is full.

module sql_token_scanner_unit
   import sts_pkg::*;
#(
   parameter int MAX_STATEMENT = STS_MAX_STATEMENT,
   parameter int KEYWORD_CHARS = STS_KEYWORD_CHARS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_word
);

   localparam int PW        = $clog2(MAX_STATEMENT + 1);
   localparam int WW        = 8 * KEYWORD_CHARS;
   localparam int START_LIM = (MAX_STATEMENT - 1 < 4095) ? MAX_STATEMENT - 1 : 4095;
   localparam int LEN_LIM   = 8191;
   localparam logic [PW-1:0] POS_MAX = PW'(MAX_STATEMENT);

   function automatic logic [PW-1:0] sat_inc(logic [PW-1:0] v);
      return (v == POS_MAX) ? v : v + PW'(1);
   endfunction

   function automatic logic [11:0] sat_start(logic [PW-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'(START_LIM)) ? 12'(START_LIM) : w[11:0];
   endfunction

   function automatic logic [12:0] sat_len(logic [PW-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (w > 32'(LEN_LIM)) ? 13'(LEN_LIM) : w[12:0];
   endfunction

   function automatic rsp_type mk_rec(logic [4:0] k, logic [11:0] s, logic [12:0] l,
                                      logic [1:0] st);
      rsp_type r;
      r.token_kind   = k;
      r.token_start  = s;
      r.token_length = l;
      r.status       = st;
      r.last_of_run  = 1'b0;
      return r;
   endfunction

   logic          in_valid_ff, in_valid_in;
   req_type       in_ff, in_in;

   scan_mode_type mode_ff, mode_in, mode_s;
   logic [PW-1:0] pos_ff, pos_in, pos_inc;
   logic [PW-1:0] begin_ff, begin_in, begin_s;
   logic [PW-1:0] count_ff, count_in, count_s;
   logic [WW-1:0] win_ff, win_in, win_s;
   logic          err_ff, err_in, err_s;

   rsp_type       rb_ff [STS_MAX_RECS];
   rsp_type       rb_in [STS_MAX_RECS];
   logic [1:0]    rb_cnt_ff, rb_cnt_in;

   rsp_type       recs [STS_MAX_RECS];
   logic [1:0]    nrec;

   logic [7:0]    c;
   logic          ext, starts_tok, rb_done, move, pop;

   assign c          = in_ff.char_code;
   assign ext        = (mode_ff == MODE_WORD && is_word(c)) ||
                       (mode_ff == MODE_NUM && is_digit(c));
   assign starts_tok = is_alpha(c) || c == "_" || is_digit(c) || c == "'";
   assign pos_inc    = sat_inc(pos_ff);

   assign rsp_valid = rb_cnt_ff != 2'd0;
   assign rsp_word  = rb_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   assign rb_done   = !rsp_valid || (rsp_ready && rb_cnt_ff == 2'd1);
   assign move      = in_valid_ff && rb_done;
   assign req_ready = !in_valid_ff || move;

   // scan state after this byte, before end-of-statement clearing
   always_comb begin
      mode_s  = mode_ff;
      begin_s = begin_ff;
      count_s = count_ff;
      win_s   = win_ff;
      err_s   = err_ff;
      if (!err_ff) begin
         if (mode_ff == MODE_STR) begin
            if (c == "'") begin
               mode_s = MODE_IDLE;
            end else begin
               count_s = sat_inc(count_ff);
            end
         end else if (ext) begin
            if (mode_ff == MODE_WORD) begin
               for (int i = 0; i < KEYWORD_CHARS; i++) begin
                  if (count_ff == PW'(i)) begin
                     win_s[8*i +: 8] = to_upper(c);
                  end
               end
            end
            count_s = sat_inc(count_ff);
         end else begin
            mode_s = MODE_IDLE;
            if (is_alpha(c) || c == "_") begin
               mode_s  = MODE_WORD;
               begin_s = pos_ff;
               count_s = PW'(1);
               win_s   = WW'(to_upper(c));
            end else if (is_digit(c)) begin
               mode_s  = MODE_NUM;
               begin_s = pos_ff;
               count_s = PW'(1);
            end else if (c == "'") begin
               mode_s  = MODE_STR;
               begin_s = pos_inc;
               count_s = '0;
            end else if (!is_space(c) && sym_kind(c) == KIND_ERROR) begin
               err_s = 1'b1;
            end
         end
      end
   end

   always_comb begin
      if (in_ff.last_char) begin
         mode_in  = MODE_IDLE;
         pos_in   = '0;
         begin_in = '0;
         count_in = '0;
         win_in   = '0;
         err_in   = 1'b0;
      end else begin
         mode_in  = mode_s;
         pos_in   = pos_inc;
         begin_in = begin_s;
         count_in = count_s;
         win_in   = win_s;
         err_in   = err_s;
      end
   end

   // records for this byte, in order
   always_comb begin
      recs = '{default: '0};
      nrec = 2'd0;
      if (!err_ff) begin
         if (mode_ff == MODE_STR) begin
            if (c == "'") begin
               recs[nrec] = mk_rec(KIND_STRING, sat_start(begin_ff), sat_len(count_ff),
                                   STAT_OK);
               nrec = nrec + 2'd1;
            end
         end else if (!ext) begin
            if (mode_ff == MODE_WORD) begin
               recs[nrec] = mk_rec(kw_kind(64'(win_ff), count_ff[3:0],
                                           count_ff > PW'(KEYWORD_CHARS)),
                                   sat_start(begin_ff), sat_len(count_ff), STAT_OK);
               nrec = nrec + 2'd1;
            end else if (mode_ff == MODE_NUM) begin
               recs[nrec] = mk_rec(KIND_NUMBER, sat_start(begin_ff), sat_len(count_ff),
                                   STAT_OK);
               nrec = nrec + 2'd1;
            end
            if (!is_space(c) && !starts_tok) begin
               if (sym_kind(c) != KIND_ERROR) begin
                  recs[nrec] = mk_rec(sym_kind(c), sat_start(pos_ff), 13'd1, STAT_OK);
               end else begin
                  recs[nrec] = mk_rec(KIND_ERROR, sat_start(pos_ff), 13'd0, STAT_INVALID);
               end
               nrec = nrec + 2'd1;
            end
         end
      end
      if (in_ff.last_char) begin
         if (!err_s) begin
            if (mode_s == MODE_STR) begin
               recs[nrec] = mk_rec(KIND_ERROR, sat_start(begin_s), sat_len(count_s),
                                   STAT_UNTERM);
               nrec = nrec + 2'd1;
            end else if (mode_s == MODE_WORD) begin
               recs[nrec] = mk_rec(kw_kind(64'(win_s), count_s[3:0],
                                           count_s > PW'(KEYWORD_CHARS)),
                                   sat_start(begin_s), sat_len(count_s), STAT_OK);
               nrec = nrec + 2'd1;
            end else if (mode_s == MODE_NUM) begin
               recs[nrec] = mk_rec(KIND_NUMBER, sat_start(begin_s), sat_len(count_s),
                                   STAT_OK);
               nrec = nrec + 2'd1;
            end
         end
         recs[nrec] = mk_rec(KIND_END, sat_start(pos_inc), 13'd0, STAT_OK);
         nrec = nrec + 2'd1;
      end
      if (nrec != 2'd0) begin
         recs[nrec - 2'd1].last_of_run = 1'b1;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_in       = req_word;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rb_in     = rb_ff;
      rb_cnt_in = rb_cnt_ff;
      if (move) begin
         rb_in     = recs;
         rb_cnt_in = nrec;
      end else if (pop) begin
         rb_in[0]  = rb_ff[1];
         rb_in[1]  = rb_ff[2];
         rb_cnt_in = rb_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rb_cnt_ff   <= 2'd0;
         mode_ff     <= MODE_IDLE;
         pos_ff      <= '0;
         begin_ff    <= '0;
         count_ff    <= '0;
         win_ff      <= '0;
         err_ff      <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         rb_cnt_ff   <= rb_cnt_in;
         if (move) begin
            mode_ff  <= mode_in;
            pos_ff   <= pos_in;
            begin_ff <= begin_in;
            count_ff <= count_in;
            win_ff   <= win_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      rb_ff <= rb_in;
   end

endmodule

// ===== rtl/core/sts_checker.sv =====
`timescale 1ns / 1ps

module sts_checker
   import sts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_word))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_end_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.token_kind == KIND_END |->
         rsp_word.token_length == 13'd0 && rsp_word.status == STAT_OK &&
         rsp_word.last_of_run)
      else $error("malformed end record");

   a_unterm_rec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == STAT_UNTERM |->
         rsp_word.token_kind == KIND_ERROR && !rsp_word.last_of_run)
      else $error("unterminated string record not followed by end");

endmodule

bind sql_token_scanner_unit sts_checker u_sts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);
